// ===== design/rgbcv_pkg.sv =====
// Shared types, constants and kernel arithmetic of the RGB 3x3 convolution block.
package rgbcv_pkg;

    // Width of a signed channel sum; the largest kernel magnitude times 255 fits with margin.
    localparam int SUM_W = 20;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam int KSEL_W       = 3;
    localparam int KSEL_MIN     = 1;
    localparam int KSEL_MAX     = 6;
    localparam int KSEL_RESET   = 1;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Line counting: the input row counter must reach the height itself.
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = 13;
    localparam int OROW_W       = 12;

    // Output queue.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

    // Kernels scaled by 64, row-major, top row first, left column first.
    localparam int KERNEL [0:5][0:8] = '{
        '{   1,    4,   1,    4,  44,   4,    1,   4,   1 },
        '{   0,  -64,   0,  -64, 320, -64,    0, -64,   0 },
        '{ -64, -128, -64,    0,   0,   0,   64, 128,  64 },
        '{ -64,    0,  64,  -64,   0,  64,  -64,   0,  64 },
        '{ -64,  -64, -64,  -64, 512, -64,  -64, -64, -64 },
        '{-128,  -64,   0,  -64,  64,  64,    0,  64, 128 }
    };

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One window column, top line first.
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    // One line-buffer entry: the pixel two lines up and the pixel one line up.
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_t;

    typedef struct packed {
        sum_t red;
        sum_t green;
        sum_t blue;
    } rgb_sum_t;

    typedef struct packed {
        logic              shift;
        logic              calc;
        logic [KSEL_W-1:0] sel;
    } cell_ctrl_t;

    // What a request carries down the pipeline besides its pixel.
    typedef struct packed {
        logic shift;
        logic emit;
        logic interior;
        logic last;
    } item_t;

    typedef struct packed {
        logic       last;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } result_t;

    // Pixel times a kernel coefficient; every coefficient is a sum of at most three powers of two.
    function automatic sum_t tap_product(input logic [7:0] px, input int coef);
        sum_t p;
        sum_t prod;
        p = {{(SUM_W-8){1'b0}}, px};
        case (coef)
            1:       prod = p;
            4:       prod = p <<< 2;
            44:      prod = (p <<< 5) + (p <<< 3) + (p <<< 2);
            64:      prod = p <<< 6;
            128:     prod = p <<< 7;
            320:     prod = (p <<< 8) + (p <<< 6);
            512:     prod = p <<< 9;
            -64:     prod = -(p <<< 6);
            -128:    prod = -(p <<< 7);
            default: prod = '0;
        endcase
        return prod;
    endfunction

endpackage

// ===== design/rgbcv_cell.sv =====
// One column cell of the 3x3 window: holds a pixel column and forms its weighted partial sum.
module rgbcv_cell #(
    parameter int COL = 0
) (
    input  logic                   clk,
    input  rgbcv_pkg::cell_ctrl_t  ctrl,
    input  rgbcv_pkg::column_t     col_in,
    output rgbcv_pkg::column_t     col_out,
    output rgbcv_pkg::rgb_sum_t    part
);

    rgbcv_pkg::column_t  col_reg;
    rgbcv_pkg::rgb_sum_t part_reg;
    rgbcv_pkg::rgb_sum_t part_next;
    rgbcv_pkg::pixel_t   taps [3];

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
        if (ctrl.calc)
        begin
            part_reg <= part_next;
        end
    end

    assign taps[0] = col_reg.top;
    assign taps[1] = col_reg.mid;
    assign taps[2] = col_reg.bot;

    // Three taps of this column, each weighted by its row's coefficient.
    always_comb
    begin
        part_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            part_next.red   = part_next.red
                + rgbcv_pkg::tap_product(taps[r].red,   rgbcv_pkg::KERNEL[ctrl.sel][r*3+COL]);
            part_next.green = part_next.green
                + rgbcv_pkg::tap_product(taps[r].green, rgbcv_pkg::KERNEL[ctrl.sel][r*3+COL]);
            part_next.blue  = part_next.blue
                + rgbcv_pkg::tap_product(taps[r].blue,  rgbcv_pkg::KERNEL[ctrl.sel][r*3+COL]);
        end
    end

    assign col_out = col_reg;
    assign part    = part_reg;

endmodule

// ===== design/rgbcv_linebuf.sv =====
// Line buffer memory holding the two previous lines, one entry per column.
module rgbcv_linebuf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output rgbcv_pkg::line_t    rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  rgbcv_pkg::line_t    wr_data
);

    rgbcv_pkg::line_t mem [DEPTH];
    rgbcv_pkg::line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/rgb_conv3x3_preset_kernels.sv =====
// Top level of the streaming RGB 3x3 convolution with six preset kernels.
//
//  Channel   Direction  Signals                          Contents
//  s_        in         s_tvalid s_tready s_tdata s_tuser  pixel or flush request
//  m_        out        m_tvalid m_tready m_tdata m_tlast  filtered pixel, end of frame
//  cfg_      in         cfg_we cfg_index cfg_data          kernel, width, height
//
// One request is taken every clock cycle while s_tready is high; the request that
// causes a result passes the line buffer read, window column cells and final sum.
// The window is a chain of three column cells fed from the line buffer; the
// line buffer's single read and single write per cycle set the one-pixel rate.
// Reset restores configuration defaults, clears counters, pipeline and output queue;
// the line buffer has no clearing pass: no border output depends on unwritten entries.
// The pipeline never stalls; s_tready falls only when eight requests are
// queued or still in flight towards the output queue.
module rgb_conv3x3_preset_kernels #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input pixel stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // red_in, green_in, blue_in
    input  logic                                s_tuser,   // command: 1 = flush
    // Output pixel stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // red_out, green_out, blue_out
    output logic                                m_tlast,   // frame_last
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [rgbcv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbcv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Column address and effective width widths.
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    // Configuration registers. The kernel is kept as a table index (select minus one).
    logic [rgbcv_pkg::KSEL_W-1:0]       kidx_reg;
    logic [rgbcv_pkg::WIDTH_REG_W-1:0]  fw_reg;
    logic [rgbcv_pkg::HEIGHT_REG_W-1:0] fh_reg;

    // Frame position of the next input pixel and of the next output.
    logic [AW-1:0]                col_reg,  col_next;
    logic [rgbcv_pkg::ROW_W-1:0]  row_reg,  row_next;
    logic [AW-1:0]                ocol_reg, ocol_next;
    logic [rgbcv_pkg::OROW_W-1:0] orow_reg, orow_next;

    logic [CW-1:0]                w_eff;
    logic [rgbcv_pkg::ROW_W-1:0]  h_eff;
    logic [CW-1:0]                col_inc;
    logic [CW-1:0]                ocol_inc;

    logic             acc;
    logic             complete;
    logic             is_flush;
    logic             data_emit;
    logic             out_last;
    logic             geom_write;
    rgbcv_pkg::item_t acc_item;

    // Pipeline: stage 1 holds the line buffer read, stage 2 the shifted window,
    // stage 3 the registered partial sums.
    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg;
    rgbcv_pkg::item_t  p1_item_reg,  p2_item_reg,  p3_item_reg;
    rgbcv_pkg::pixel_t p1_px_reg;
    logic [AW-1:0]     p1_addr_reg;

    rgbcv_pkg::line_t      line_rd;
    rgbcv_pkg::line_t      line_wr;
    rgbcv_pkg::cell_ctrl_t cell_ctrl;
    rgbcv_pkg::column_t    col_feed [3];
    rgbcv_pkg::rgb_sum_t   parts    [3];
    rgbcv_pkg::rgb_sum_t   total;

    // Output queue.
    rgbcv_pkg::result_t                 q_mem [rgbcv_pkg::OUT_DEPTH];
    logic [rgbcv_pkg::OUT_PTR_W-1:0]    q_wptr_reg, q_rptr_reg;
    logic [rgbcv_pkg::OUT_CNT_W-1:0]    q_cnt_reg,  q_cnt_next;
    logic [rgbcv_pkg::OUT_CNT_W-1:0]    occupancy;
    logic                               q_wr;
    logic                               q_rd;
    rgbcv_pkg::result_t                 q_wdata;
    rgbcv_pkg::result_t                 q_rdata;

    function automatic logic [7:0] clamp_chan(input rgbcv_pkg::sum_t s);
        rgbcv_pkg::sum_t q;
        logic [7:0]      v;
        q = s >>> 6;
        if (s <= rgbcv_pkg::sum_t'(0))
        begin
            v = 8'd0;
        end
        else if (q > rgbcv_pkg::sum_t'(255))
        begin
            v = 8'hFF;
        end
        else
        begin
            v = q[7:0];
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Effective geometry: zero acts as one, and values beyond the limits saturate.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (fw_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(fw_reg);
        end

        if (fh_reg == '0)
        begin
            h_eff = rgbcv_pkg::ROW_W'(1);
        end
        else if (32'(fh_reg) > 32'(rgbcv_pkg::HEIGHT_LIMIT))
        begin
            h_eff = rgbcv_pkg::ROW_W'(rgbcv_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = fh_reg;
        end
    end

    // ------------------------------------------------------------------
    // Request decode. Once every input pixel of the frame is in, any request
    // drains one border output; a flush before that point is dropped.
    // Input pixel p releases output p - W - 1, so outputs start at row one,
    // column one of the input.
    // ------------------------------------------------------------------
    assign occupancy = q_cnt_reg
                     + rgbcv_pkg::OUT_CNT_W'(p1_valid_reg)
                     + rgbcv_pkg::OUT_CNT_W'(p2_valid_reg)
                     + rgbcv_pkg::OUT_CNT_W'(p3_valid_reg);
    assign s_tready  = occupancy < rgbcv_pkg::OUT_CNT_W'(rgbcv_pkg::OUT_DEPTH);
    assign acc       = s_tvalid && s_tready;

    assign complete  = row_reg >= h_eff;
    assign is_flush  = s_tuser || complete;
    assign data_emit = (row_reg >= rgbcv_pkg::ROW_W'(2))
                    || ((row_reg == rgbcv_pkg::ROW_W'(1)) && (col_reg != '0));
    assign out_last  = (CW'(ocol_reg) == (w_eff - CW'(1)))
                    && ({1'b0, orow_reg} == (h_eff - rgbcv_pkg::ROW_W'(1)));

    always_comb
    begin
        acc_item.shift    = !is_flush;
        acc_item.emit     = is_flush ? complete : data_emit;
        acc_item.interior = !is_flush && (col_reg >= AW'(2))
                         && (row_reg >= rgbcv_pkg::ROW_W'(2));
        acc_item.last     = out_last;
    end

    assign geom_write = cfg_we
                     && ((cfg_index == rgbcv_pkg::REG_WIDTH)
                      || (cfg_index == rgbcv_pkg::REG_HEIGHT));
    assign col_inc    = CW'(col_reg) + CW'(1);
    assign ocol_inc   = CW'(ocol_reg) + CW'(1);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (geom_write)
        begin
            // A new geometry restarts the frame.
            col_next  = '0;
            row_next  = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (acc)
        begin
            if (!is_flush)
            begin
                if (col_inc >= w_eff)
                begin
                    col_next = '0;
                    row_next = row_reg + rgbcv_pkg::ROW_W'(1);
                end
                else
                begin
                    col_next = AW'(col_inc);
                end
            end
            if (acc_item.emit)
            begin
                if (out_last)
                begin
                    col_next  = '0;
                    row_next  = '0;
                    ocol_next = '0;
                    orow_next = '0;
                end
                else if (ocol_inc >= w_eff)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + rgbcv_pkg::OROW_W'(1);
                end
                else
                begin
                    ocol_next = AW'(ocol_inc);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers: configuration, counters and pipeline control.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kidx_reg     <= rgbcv_pkg::KSEL_W'(rgbcv_pkg::KSEL_RESET - 1);
            fw_reg       <= rgbcv_pkg::WIDTH_REG_W'(rgbcv_pkg::WIDTH_RESET);
            fh_reg       <= rgbcv_pkg::HEIGHT_REG_W'(rgbcv_pkg::HEIGHT_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            q_wptr_reg   <= '0;
            q_rptr_reg   <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            // Kernel codes outside the preset list leave the selection as it is.
            if (cfg_we && (cfg_index == rgbcv_pkg::REG_KERNEL)
                && (cfg_data[rgbcv_pkg::KSEL_W-1:0] >= rgbcv_pkg::KSEL_W'(rgbcv_pkg::KSEL_MIN))
                && (cfg_data[rgbcv_pkg::KSEL_W-1:0] <= rgbcv_pkg::KSEL_W'(rgbcv_pkg::KSEL_MAX)))
            begin
                kidx_reg <= cfg_data[rgbcv_pkg::KSEL_W-1:0] - rgbcv_pkg::KSEL_W'(1);
            end
            if (cfg_we && (cfg_index == rgbcv_pkg::REG_WIDTH))
            begin
                fw_reg <= cfg_data[rgbcv_pkg::WIDTH_REG_W-1:0];
            end
            if (cfg_we && (cfg_index == rgbcv_pkg::REG_HEIGHT))
            begin
                fh_reg <= cfg_data;
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            ocol_reg     <= ocol_next;
            orow_reg     <= orow_next;
            p1_valid_reg <= acc;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (q_wr)
            begin
                q_wptr_reg <= q_wptr_reg + rgbcv_pkg::OUT_PTR_W'(1);
            end
            if (q_rd)
            begin
                q_rptr_reg <= q_rptr_reg + rgbcv_pkg::OUT_PTR_W'(1);
            end
            q_cnt_reg <= q_cnt_next;
        end
    end

    // Payload of the pipeline stages.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p1_item_reg <= acc_item;
            p1_addr_reg <= col_reg;
            p1_px_reg   <= '{red: s_tdata[7:0], green: s_tdata[15:8], blue: s_tdata[23:16]};
        end
        p2_item_reg <= p1_item_reg;
        p3_item_reg <= p2_item_reg;
    end

    // ------------------------------------------------------------------
    // Line buffer: read the column at accept time, and in the following cycle move
    // the middle line up and store the new pixel as the middle line.
    // ------------------------------------------------------------------
    assign line_wr = '{upper: line_rd.middle, middle: p1_px_reg};

    rgbcv_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (acc && acc_item.shift),
        .rd_addr (col_reg),
        .rd_data (line_rd),
        .wr_en   (p1_valid_reg && p1_item_reg.shift),
        .wr_addr (p1_addr_reg),
        .wr_data (line_wr)
    );

    // ------------------------------------------------------------------
    // Window: three column cells. The newest column enters the right-hand
    // cell and moves one cell left with every data pixel.
    // ------------------------------------------------------------------
    assign cell_ctrl.shift = p1_valid_reg && p1_item_reg.shift;
    assign cell_ctrl.calc  = p2_valid_reg;
    assign cell_ctrl.sel   = kidx_reg;

    assign col_feed[2] = '{top: line_rd.upper, mid: line_rd.middle, bot: p1_px_reg};

    for (genvar j = 0; j < 3; j++)
    begin : g_cell
        if (j == 0)
        begin : g_left
            rgbcv_cell #(
                .COL (j)
            ) u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .col_in  (col_feed[j]),
                .col_out (),
                .part    (parts[j])
            );
        end
        else
        begin : g_inner
            rgbcv_cell #(
                .COL (j)
            ) u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .col_in  (col_feed[j]),
                .col_out (col_feed[j-1]),
                .part    (parts[j])
            );
        end
    end

    // ------------------------------------------------------------------
    // Final sum, floor by 64, clamp, and border forcing.
    // ------------------------------------------------------------------
    always_comb
    begin
        total.red   = parts[0].red   + parts[1].red   + parts[2].red;
        total.green = parts[0].green + parts[1].green + parts[2].green;
        total.blue  = parts[0].blue  + parts[1].blue  + parts[2].blue;
        q_wdata.last  = p3_item_reg.last;
        q_wdata.red   = p3_item_reg.interior ? clamp_chan(total.red)   : 8'd0;
        q_wdata.green = p3_item_reg.interior ? clamp_chan(total.green) : 8'd0;
        q_wdata.blue  = p3_item_reg.interior ? clamp_chan(total.blue)  : 8'd0;
    end

    // ------------------------------------------------------------------
    // Output queue.
    // ------------------------------------------------------------------
    assign q_wr = p3_valid_reg && p3_item_reg.emit;
    assign q_rd = m_tvalid && m_tready;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (q_wr && !q_rd)
        begin
            q_cnt_next = q_cnt_reg + rgbcv_pkg::OUT_CNT_W'(1);
        end
        else if (!q_wr && q_rd)
        begin
            q_cnt_next = q_cnt_reg - rgbcv_pkg::OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
        begin
            q_mem[q_wptr_reg] <= q_wdata;
        end
    end

    assign q_rdata  = q_mem[q_rptr_reg];
    assign m_tvalid = q_cnt_reg != '0;
    assign m_tdata  = {q_rdata.blue, q_rdata.green, q_rdata.red};
    assign m_tlast  = q_rdata.last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr && !q_rd
          && (q_cnt_reg == rgbcv_pkg::OUT_CNT_W'(rgbcv_pkg::OUT_DEPTH))))
        else $error("output queue written while full");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= rgbcv_pkg::OUT_CNT_W'(rgbcv_pkg::OUT_DEPTH))
        else $error("more requests in flight than queue entries");

    a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc && acc_item.emit |-> ##3 q_wr)
        else $error("emitting request did not reach the output queue");

    a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(col_reg) < w_eff)
        else $error("input column beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_eff)
        else $error("input row beyond frame height");

endmodule
